// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off while in reset
`define SKT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while in reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// shared sizes, codes and types of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int KEY_WIDTH     = 40;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = IDX_W + 1;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 3;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REKEY  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_CMP2,
        S_EXEC2,
        S_PICK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                load_in;
        logic                cmp_en;
        logic                cmp_new;
        logic                ins;
        logic                ins_saved;
        logic                del;
        logic                clr;
        logic                sel;
        logic                out_load;
        logic                pick;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic new_dup;
        logic full;
        logic empty;
        logic out_busy;
    } stat_t;

endpackage

// ----- hdl/skt_req_if.sv -----
// ----------------------------------------------------------------------------
// skt_req_if
// request channel: operation, keys and payload
// ----------------------------------------------------------------------------
interface skt_req_if
    import skt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [KEY_WIDTH-1:0]     key;
    logic [KEY_WIDTH-1:0]     new_key;
    logic [PAYLOAD_WIDTH-1:0] payload_in;

    modport source (output valid, func, key, new_key, payload_in, input ready);
    modport sink (input valid, func, key, new_key, payload_in, output ready);
endinterface

// ----- hdl/skt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// skt_rsp_if
// response channel: status, chosen entry and entry count
// ----------------------------------------------------------------------------
interface skt_rsp_if
    import skt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [KEY_WIDTH-1:0]     hit_key;
    logic [PAYLOAD_WIDTH-1:0] payload_out;
    logic [CNT_W-1:0]         entry_count;

    modport source (output valid, status, hit_key, payload_out, entry_count, input ready);
    modport sink (input valid, status, hit_key, payload_out, entry_count, output ready);
endinterface

// ----- hdl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// operation sequencer: compare pass, shift or select, result load
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [FUNC_W-1:0] req_func,
    output logic              req_ready,
    input  stat_t             stat,
    output cmd_t              cmd
);

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [STATUS_W-1:0] st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg  <= FN_LOOKUP;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            if (req_valid && req_ready)
            begin
                func_reg <= req_func;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_EXEC;
            S_EXEC:
            begin
                if (func_reg == FN_LOOKUP && !stat.empty)
                begin
                    state_next = S_PICK;
                end
                else if (func_reg == FN_REKEY && stat.found && !stat.new_dup)
                begin
                    state_next = S_CMP2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP2:  state_next = S_EXEC2;
            S_EXEC2: state_next = S_DONE;
            S_PICK, S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        st_next   = st_reg;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.load_in = req_valid;
            end
            S_CMP:
            begin
                cmd.cmp_en = 1'b1;
            end
            S_EXEC:
            begin
                st_next = ST_OK;
                case (func_reg)
                    FN_LOOKUP:
                    begin
                        if (stat.empty)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.sel = 1'b1;
                        end
                    end
                    FN_INSERT:
                    begin
                        if (stat.found)
                        begin
                            st_next = ST_DUP;
                        end
                        else if (stat.full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.ins = 1'b1;
                        end
                    end
                    FN_REKEY:
                    begin
                        if (!stat.found)
                        begin
                            st_next = ST_NOTFOUND;
                        end
                        else if (stat.new_dup)
                        begin
                            st_next = ST_DUP;
                        end
                        else
                        begin
                            cmd.del = 1'b1;
                        end
                    end
                    FN_DELETE:
                    begin
                        if (stat.found)
                        begin
                            cmd.del = 1'b1;
                        end
                        else
                        begin
                            st_next = ST_NOTFOUND;
                        end
                    end
                    FN_CLEAR:
                    begin
                        cmd.clr = 1'b1;
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
            S_CMP2:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.cmp_new = 1'b1;
            end
            S_EXEC2:
            begin
                cmd.ins       = 1'b1;
                cmd.ins_saved = 1'b1;
            end
            S_PICK:
            begin
                cmd.out_load = !stat.out_busy;
                cmd.pick     = 1'b1;
                cmd.status   = ST_OK;
            end
            S_DONE:
            begin
                cmd.out_load = !stat.out_busy;
                cmd.status   = st_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/skt_datapath.sv -----
// ----------------------------------------------------------------------------
// skt_datapath
// table cells with per-cell compare, shift network, nearest pick, result reg
// ----------------------------------------------------------------------------
module skt_datapath
    import skt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  logic [KEY_WIDTH-1:0]     req_key,
    input  logic [KEY_WIDTH-1:0]     req_new_key,
    input  logic [PAYLOAD_WIDTH-1:0] req_payload,
    input  logic                     rsp_ready,
    output logic                     rsp_valid,
    output logic [STATUS_W-1:0]      rsp_status,
    output logic [KEY_WIDTH-1:0]     rsp_hit_key,
    output logic [PAYLOAD_WIDTH-1:0] rsp_payload,
    output logic [CNT_W-1:0]         rsp_count
);

    logic [KEY_WIDTH-1:0]     keys_reg [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]     keys_next [TABLE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pays_reg [TABLE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pays_next [TABLE_DEPTH];
    logic [CNT_W-1:0]         count_reg, count_next;

    logic [KEY_WIDTH-1:0]     key_reg, new_key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, saved_pay_reg;
    logic [TABLE_DEPTH-1:0]   lt_reg, eq_reg, eqn_reg;
    logic [TABLE_DEPTH-1:0]   lt_next, eq_next, eqn_next;
    logic [TABLE_DEPTH-1:0]   valid_vec, up_vec, lo_vec;

    logic [KEY_WIDTH-1:0]     target, ins_key;
    logic [PAYLOAD_WIDTH-1:0] ins_pay, hit_pay;

    logic [KEY_WIDTH-1:0]     up_key, lo_key, up_key_reg, lo_key_reg;
    logic [PAYLOAD_WIDTH-1:0] up_pay, lo_pay, up_pay_reg, lo_pay_reg;
    logic                     has_up_reg, has_lo_reg;
    logic [KEY_WIDTH-1:0]     diff_lo, diff_up;
    logic                     take_lo;

    assign target  = cmd.cmp_new ? new_key_reg : key_reg;
    assign ins_key = cmd.ins_saved ? new_key_reg : key_reg;
    assign ins_pay = cmd.ins_saved ? saved_pay_reg : pay_reg;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            assign valid_vec[g] = CNT_W'(g) < count_reg;
            assign lt_next[g]   = valid_vec[g] && (keys_reg[g] < target);
            assign eq_next[g]   = valid_vec[g] && (keys_reg[g] == key_reg);
            assign eqn_next[g]  = valid_vec[g] && (keys_reg[g] == new_key_reg);

            // first cell at or above the query, and last cell below it
            if (g == 0)
            begin : g_first
                assign up_vec[g] = valid_vec[g] && !lt_reg[g];
            end
            else
            begin : g_rest
                assign up_vec[g] = valid_vec[g] && !lt_reg[g] && lt_reg[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign lo_vec[g] = lt_reg[g];
            end
            else
            begin : g_inner
                assign lo_vec[g] = lt_reg[g] && !lt_reg[g+1];
            end

            always_comb
            begin
                keys_next[g] = keys_reg[g];
                pays_next[g] = pays_reg[g];
                if (cmd.ins && !lt_reg[g])
                begin
                    if (g == 0)
                    begin
                        keys_next[g] = ins_key;
                        pays_next[g] = ins_pay;
                    end
                    else if (lt_reg[(g > 0) ? g - 1 : 0])
                    begin
                        keys_next[g] = ins_key;
                        pays_next[g] = ins_pay;
                    end
                    else
                    begin
                        keys_next[g] = keys_reg[(g > 0) ? g - 1 : 0];
                        pays_next[g] = pays_reg[(g > 0) ? g - 1 : 0];
                    end
                end
                else if (cmd.del && !lt_reg[g] && g < TABLE_DEPTH - 1)
                begin
                    keys_next[g] = keys_reg[(g < TABLE_DEPTH - 1) ? g + 1 : g];
                    pays_next[g] = pays_reg[(g < TABLE_DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        up_key  = '0;
        lo_key  = '0;
        up_pay  = '0;
        lo_pay  = '0;
        hit_pay = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            up_key  = up_key | ({KEY_WIDTH{up_vec[i]}} & keys_reg[i]);
            lo_key  = lo_key | ({KEY_WIDTH{lo_vec[i]}} & keys_reg[i]);
            up_pay  = up_pay | ({PAYLOAD_WIDTH{up_vec[i]}} & pays_reg[i]);
            lo_pay  = lo_pay | ({PAYLOAD_WIDTH{lo_vec[i]}} & pays_reg[i]);
            hit_pay = hit_pay | ({PAYLOAD_WIDTH{eq_reg[i]}} & pays_reg[i]);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // tie goes to the earlier key; past either end only one side exists
    assign diff_lo = key_reg - lo_key_reg;
    assign diff_up = up_key_reg - key_reg;
    assign take_lo = !has_up_reg || (has_lo_reg && diff_lo <= diff_up);

    assign stat.found    = |eq_reg;
    assign stat.new_dup  = |eqn_reg;
    assign stat.full     = count_reg >= CNT_W'(TABLE_DEPTH);
    assign stat.empty    = count_reg == '0;
    assign stat.out_busy = rsp_valid && !rsp_ready;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            keys_reg[i] <= keys_next[i];
            pays_reg[i] <= pays_next[i];
        end
        if (cmd.load_in)
        begin
            key_reg     <= req_key;
            new_key_reg <= req_new_key;
            pay_reg     <= req_payload;
        end
        if (cmd.cmp_en)
        begin
            lt_reg  <= lt_next;
            eq_reg  <= eq_next;
            eqn_reg <= eqn_next;
        end
        if (cmd.del)
        begin
            saved_pay_reg <= hit_pay;
        end
        if (cmd.sel)
        begin
            up_key_reg <= up_key;
            lo_key_reg <= lo_key;
            up_pay_reg <= up_pay;
            lo_pay_reg <= lo_pay;
            has_up_reg <= |up_vec;
            has_lo_reg <= |lo_vec;
        end
        if (cmd.out_load)
        begin
            rsp_status  <= cmd.status;
            rsp_count   <= count_reg;
            rsp_hit_key <= cmd.pick ? (take_lo ? lo_key_reg : up_key_reg) : '0;
            rsp_payload <= cmd.pick ? (take_lo ? lo_pay_reg : up_pay_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rsp_valid <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                rsp_valid <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/sorted_key_table_nearest_lookup.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_nearest_lookup
// sorted table of unique keys with nearest-key lookup and edits
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req      in   func, key, new_key, payload_in
//  rsp      out  status, hit_key, payload_out, entry_count
//
//  a result is loaded after a compare pass over all cells, a shift or select
//  step and the result load (rekey adds a second compare pass and an insert
//  step before the load); the next request is accepted only after the load
//  reset empties the table at once; no clearing pass
//  a new request is taken while a result waits in the rsp register
//  a stalled rsp holds the sequencer in its last state
// ----------------------------------------------------------------------------
module sorted_key_table_nearest_lookup
    import skt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    skt_req_if.sink  req,
    skt_rsp_if.source rsp
);

    cmd_t  cmd;
    stat_t stat;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    skt_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_key     (req.key),
        .req_new_key (req.new_key),
        .req_payload (req.payload_in),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .rsp_status  (rsp.status),
        .rsp_hit_key (rsp.hit_key),
        .rsp_payload (rsp.payload_out),
        .rsp_count   (rsp.entry_count)
    );

endmodule

// ----- hdl/skt_checker.sv -----
// ----------------------------------------------------------------------------
// skt_checker
// port-level checks of the sorted key table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skt_checker
    import skt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [STATUS_W-1:0]      rsp_status,
    input logic [KEY_WIDTH-1:0]     rsp_hit_key,
    input logic [PAYLOAD_WIDTH-1:0] rsp_payload,
    input logic [CNT_W-1:0]         rsp_count
);

    `SKT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
    `SKT_ASSERT_IMP(a_count_max, rsp_valid, rsp_count <= CNT_W'(TABLE_DEPTH))
    `SKT_ASSERT_IMP(a_status_code, rsp_valid, rsp_status <= ST_FULL)
    `SKT_ASSERT_IMP(a_err_zero, rsp_valid && rsp_status != ST_OK,
        rsp_hit_key == '0 && rsp_payload == '0)
    `SKT_ASSERT_IMP(a_full_count, rsp_valid && rsp_status == ST_FULL,
        rsp_count == CNT_W'(TABLE_DEPTH))

endmodule

bind sorted_key_table_nearest_lookup skt_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_hit_key (rsp.hit_key),
    .rsp_payload (rsp.payload_out),
    .rsp_count   (rsp.entry_count)
);
